/* sv/llcb_pkg.sv */
package llcb_pkg;

  localparam int LEVELS    = 16;
  localparam int LVL_W     = $clog2(LEVELS);
  localparam int LEVEL_W   = 4;
  localparam int CH_W      = 10;
  localparam int NUM_CH    = 4;
  localparam int COLOR_W   = CH_W * NUM_CH;
  localparam int CFG_IDX_W = 3;
  localparam int CURVE_W   = 16;
  localparam int ATT_W     = 25;
  localparam int TERM_W    = 28;
  localparam int SUM_W     = 54;
  localparam int CLAMP_W   = 49;
  localparam int PIX_W     = 8;

  localparam logic [COLOR_W-1:0] DARK_RST  = 40'd7722885127;
  localparam logic [COLOR_W-1:0] SKY_RST   = 40'd275883245552;
  localparam logic [COLOR_W-1:0] BLOCK_RST = 40'd275146179968;
  localparam logic [CH_W-1:0]    POWER_RST = 10'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DARK  = 3'd0,
    CFG_SKY   = 3'd1,
    CFG_BLOCK = 3'd2,
    CFG_POWER = 3'd3
  } llcb_cfg_e;

  typedef struct packed {
    logic b;
    logic c;
    logic d;
    logic e;
  } llcb_en_t;

  typedef logic [CURVE_W-1:0] curve_arr_t [LEVELS];

  // (i/15)^2 in Q0.16, rounded to nearest; the top entry saturates
  localparam curve_arr_t CURVE = '{
    16'd0,     16'd291,   16'd1165,  16'd2621,
    16'd4660,  16'd7282,  16'd10486, 16'd14272,
    16'd18641, 16'd23593, 16'd29127, 16'd35244,
    16'd41943, 16'd49225, 16'd57089, 16'd65535
  };

  function automatic logic [CURVE_W-1:0] curve_lookup(input logic [LEVEL_W-1:0] lvl);
    if (int'(lvl) >= LEVELS) return CURVE[LEVELS-1];
    return CURVE[LVL_W'(lvl)];
  endfunction

endpackage

/* sv/llcb_in_if.sv */
interface llcb_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] sky_level;
  logic [3:0] block_level;

  modport source (output valid, output sky_level, output block_level, input ready);
  modport sink   (input valid, input sky_level, input block_level, output ready);
endinterface

/* sv/llcb_out_if.sv */
interface llcb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, output red, output green, output blue, output alpha,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  output ready);
endinterface

/* sv/light_level_color_blend_core.sv */
// Light level colour blend.
// lvl_i carries one transaction per pixel: a sky level and a block light level,
// each 0 to 15. pix_o returns one RGBA byte quad per accepted transaction, in order.
// The colours and the sky power are written through cfg_we_i / cfg_idx_i /
// cfg_data_i (index 0 dark, 1 sky, 2 block, 3 power) while no pixel is in flight.
// Throughput is one pixel per cycle while pix_o takes each result: five
// register stages (curve lookup, first products and attenuation, block term
// product, sum and clamp, scale to a byte), each with its own valid bit.
// When the receiver stalls, each stage holds once the stage after it is full;
// empty stages still fill, so input is taken until the whole pipe is full.
// Reset empties the pipe and loads the default colours and a power of one;
// the curve is a fixed table and needs no loading.
module light_level_color_blend_core
  import llcb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  llcb_in_if.sink              lvl_i,
  llcb_out_if.source           pix_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COLOR_W-1:0]   cfg_data_i
);

  logic [COLOR_W-1:0] dark_q, sky_q, block_q;
  logic [CH_W-1:0]    power_q;

  logic valid_a_q, valid_b_q, valid_c_q, valid_d_q, valid_e_q;
  logic valid_a_d, valid_b_d, valid_c_d, valid_d_d, valid_e_d;
  logic can_a, can_b, can_c, can_d, can_e;
  llcb_en_t en;

  logic [CURVE_W-1:0] cs_a_q, cb_a_q;
  logic [25:0]        pc;
  logic [ATT_W-1:0]   att_b_d, att_b_q;
  logic [PIX_W-1:0]   pix [NUM_CH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dark_q  <= DARK_RST;
      sky_q   <= SKY_RST;
      block_q <= BLOCK_RST;
      power_q <= POWER_RST;
    end else if (cfg_we_i) begin
      unique case (llcb_cfg_e'(cfg_idx_i))
        CFG_DARK:  dark_q  <= cfg_data_i;
        CFG_SKY:   sky_q   <= cfg_data_i;
        CFG_BLOCK: block_q <= cfg_data_i;
        CFG_POWER: power_q <= cfg_data_i[CH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    can_e = !valid_e_q || pix_o.ready;
    can_d = !valid_d_q || can_e;
    can_c = !valid_c_q || can_d;
    can_b = !valid_b_q || can_c;
    can_a = !valid_a_q || can_b;
    valid_a_d = can_a ? lvl_i.valid : valid_a_q;
    valid_b_d = can_b ? valid_a_q   : valid_b_q;
    valid_c_d = can_c ? valid_b_q   : valid_c_q;
    valid_d_d = can_d ? valid_c_q   : valid_d_q;
    valid_e_d = can_e ? valid_d_q   : valid_e_q;
    en = '{b: can_b, c: can_c, d: can_d, e: can_e};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
      valid_d_q <= 1'b0;
      valid_e_q <= 1'b0;
    end else begin
      valid_a_q <= valid_a_d;
      valid_b_q <= valid_b_d;
      valid_c_q <= valid_c_d;
      valid_d_q <= valid_d_d;
      valid_e_q <= valid_e_d;
    end
  end

  assign pc      = 26'(power_q) * 26'(cs_a_q);
  assign att_b_d = (pc >= 26'(1 << 24)) ? '0 : ATT_W'(26'(1 << 24) - pc);

  always_ff @(posedge clk_i) begin
    if (can_a) begin
      cs_a_q <= curve_lookup(lvl_i.sky_level);
      cb_a_q <= curve_lookup(lvl_i.block_level);
    end
    if (can_b) begin
      att_b_q <= att_b_d;
    end
  end

  for (genvar k = 0; k < NUM_CH; k++) begin : g_chan
    llcb_chan u_chan (
      .clk_i   (clk_i),
      .en_i    (en),
      .dark_i  (dark_q[CH_W*k +: CH_W]),
      .sky_i   (sky_q[CH_W*k +: CH_W]),
      .block_i (block_q[CH_W*k +: CH_W]),
      .cs_i    (cs_a_q),
      .cb_i    (cb_a_q),
      .att_i   (att_b_q),
      .pix_o   (pix[k])
    );
  end

  assign lvl_i.ready = can_a;
  assign pix_o.valid = valid_e_q;
  assign pix_o.red   = pix[0];
  assign pix_o.green = pix[1];
  assign pix_o.blue  = pix[2];
  assign pix_o.alpha = pix[3];

endmodule

/* sv/llcb_chan.sv */
module llcb_chan
  import llcb_pkg::*;
(
  input  logic                clk_i,
  input  llcb_en_t            en_i,
  input  logic [CH_W-1:0]     dark_i,
  input  logic [CH_W-1:0]     sky_i,
  input  logic [CH_W-1:0]     block_i,
  input  logic [CURVE_W-1:0]  cs_i,
  input  logic [CURVE_W-1:0]  cb_i,
  input  logic [ATT_W-1:0]    att_i,
  output logic [PIX_W-1:0]    pix_o
);

  logic signed [TERM_W-1:0]  sd_ext, bd_ext, cs_ext, cb_ext;
  logic signed [TERM_W-1:0]  sky_b_d, bdc_b_d;
  logic signed [TERM_W-1:0]  sky_b_q, bdc_b_q, sky_c_q;
  logic signed [SUM_W-1:0]   blk_c_d, blk_c_q;
  logic signed [SUM_W-1:0]   sum;
  logic        [CLAMP_W-1:0] v_d_d, v_d_q;
  logic        [CLAMP_W+7:0] scaled;
  logic        [PIX_W-1:0]   pix_e_q;

  assign sd_ext  = TERM_W'(signed'({1'b0, sky_i}))   - TERM_W'(signed'({1'b0, dark_i}));
  assign bd_ext  = TERM_W'(signed'({1'b0, block_i})) - TERM_W'(signed'({1'b0, dark_i}));
  assign cs_ext  = TERM_W'(signed'({1'b0, cs_i}));
  assign cb_ext  = TERM_W'(signed'({1'b0, cb_i}));
  assign sky_b_d = sd_ext * cs_ext;
  assign bdc_b_d = bd_ext * cb_ext;

  assign blk_c_d = SUM_W'(bdc_b_q) * SUM_W'(signed'({1'b0, att_i}));

  assign sum = (SUM_W'(signed'({1'b0, dark_i})) <<< 40)
             + (SUM_W'(sky_c_q) <<< 24)
             + blk_c_q;

  always_comb begin
    if (sum < 0) begin
      v_d_d = '0;
    end else if (sum > (SUM_W'(1) <<< 48)) begin
      v_d_d = CLAMP_W'(1) << 48;
    end else begin
      v_d_d = CLAMP_W'(sum);
    end
  end

  assign scaled = {v_d_q, 8'b0} - (CLAMP_W + 8)'(v_d_q);

  always_ff @(posedge clk_i) begin
    if (en_i.b) begin
      sky_b_q <= sky_b_d;
      bdc_b_q <= bdc_b_d;
    end
    if (en_i.c) begin
      sky_c_q <= sky_b_q;
      blk_c_q <= blk_c_d;
    end
    if (en_i.d) begin
      v_d_q <= v_d_d;
    end
    if (en_i.e) begin
      pix_e_q <= scaled[55:48];
    end
  end

  assign pix_o = pix_e_q;

endmodule

/* sv/llcb_checker.sv */
module llcb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_data_i
);

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("output valid during reset");

  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input stalled while output side drains");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output transaction dropped under stall");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("output payload changed under stall");

endmodule

bind light_level_color_blend_core llcb_checker u_llcb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (lvl_i.ready),
  .out_valid_i (pix_o.valid),
  .out_ready_i (pix_o.ready),
  .out_data_i  ({pix_o.alpha, pix_o.blue, pix_o.green, pix_o.red})
);
